/* rtl/core/clcf_pkg.sv */
// ----------------------------------------------------------------------------
// clcf_pkg
// Shared types and constants of the chroma line comb filter.
// ----------------------------------------------------------------------------
package clcf_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int QUARTER_W  = 18;
	localparam int OUT_LINE_W = 10;
	localparam int OUT_POS_W  = 11;

	localparam int LINE_LEN_W  = 12;
	localparam int FRAME_LN_W  = 11;
	// wide enough for every length compare at the default parameter values
	localparam int CMP_W       = 13;

	localparam int FIRST_COMB_LINE = 16;

	localparam logic [LINE_LEN_W-1:0] LINE_LENGTH_RESET = 12'd910;
	localparam logic [FRAME_LN_W-1:0] FRAME_LINES_RESET = 11'd263;

	// APB register map, decoded on paddr[2]
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_LINE_LENGTH = 1'b0;
	localparam logic REG_FRAME_LINES = 1'b1;

	typedef struct packed {
		logic signed [QUARTER_W-1:0] comb_quarters;
		logic [OUT_LINE_W-1:0]       out_line;
		logic [OUT_POS_W-1:0]        out_pos;
		logic                        last;
	} result_t;

endpackage

/* rtl/core/clcf_in_if.sv */
// ----------------------------------------------------------------------------
// clcf_in_if
// Sample channel: valid/ready handshake carrying one signed chroma sample.
// ----------------------------------------------------------------------------
interface clcf_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [clcf_pkg::SAMPLE_W-1:0]  sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

/* rtl/core/clcf_out_if.sv */
// ----------------------------------------------------------------------------
// clcf_out_if
// Result channel: valid/ready handshake carrying one filtered sample.
// ----------------------------------------------------------------------------
interface clcf_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [clcf_pkg::QUARTER_W-1:0]  comb_quarters;
	logic [clcf_pkg::OUT_LINE_W-1:0]        out_line;
	logic [clcf_pkg::OUT_POS_W-1:0]         out_pos;
	logic                                   last;

	modport source (output valid, output comb_quarters, output out_line,
		output out_pos, output last, input ready);
	modport sink   (input valid, input comb_quarters, input out_line,
		input out_pos, input last, output ready);
endinterface

/* rtl/core/chroma_line_comb_filter.sv */
// ----------------------------------------------------------------------------
// chroma_line_comb_filter
// Two-line-delay chroma comb filter over a raster of lines.
// ----------------------------------------------------------------------------
// Usage:
//   samples : signed chroma samples in raster order, one request per sample.
//   results : filtered samples in quarter units with line/position tags.
//             A sample of line L releases the sample of line L-1 at the same
//             position (none on line 0); on the frame's last line the current
//             sample follows it. Each sample's final result carries last=1.
//   APB     : line_length at 0x0, frame_lines at 0x4; write only while idle.
// Path    : an accepted sample is registered in stage 1; its results are
//   then written to the result buffer, which drives the result port.
// Throughput: one sample per clock unless stalled, set by the line store
//   (one registered read and one write per cycle). On the last line each
//   sample makes two results; the result port, one per cycle, sets the rate.
// Stall   : results queue in a four-entry buffer; samples.ready drops while
//   stage 1 holds a sample and the buffer has room for fewer than two
//   results. No request is dropped.
// Reset   : counters and buffer clear, registers return to 910/263. Line
//   store contents are not cleared; first-line outputs never read them.
// ----------------------------------------------------------------------------
module chroma_line_comb_filter #(
	parameter int MAX_LINE_SAMPLES = 2048,
	parameter int MAX_FRAME_LINES  = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	clcf_in_if.sink                             samples,
	clcf_out_if.source                          results,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [clcf_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [clcf_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [clcf_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);

	localparam int PW = $clog2(MAX_LINE_SAMPLES);
	localparam int LW = $clog2(MAX_FRAME_LINES);
	localparam int CW = clcf_pkg::CMP_W;
	localparam int SW = clcf_pkg::SAMPLE_W;
	localparam int QW = clcf_pkg::QUARTER_W;
	localparam int FIFO_DEPTH = 4;
	localparam int FP_W = $clog2(FIFO_DEPTH);

	// ---------------- configuration ----------------
	logic [clcf_pkg::LINE_LEN_W-1:0] line_length_q;
	logic [clcf_pkg::FRAME_LN_W-1:0] frame_lines_q;
	logic                            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q <= clcf_pkg::LINE_LENGTH_RESET;
			frame_lines_q <= clcf_pkg::FRAME_LINES_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				clcf_pkg::REG_LINE_LENGTH: line_length_q <= pwdata[clcf_pkg::LINE_LEN_W-1:0];
				clcf_pkg::REG_FRAME_LINES: frame_lines_q <= pwdata[clcf_pkg::FRAME_LN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			clcf_pkg::REG_LINE_LENGTH: prdata = clcf_pkg::APB_DATA_W'(line_length_q);
			clcf_pkg::REG_FRAME_LINES: prdata = clcf_pkg::APB_DATA_W'(frame_lines_q);
			default:                   prdata = '0;
		endcase
	end

	// effective lengths: zero acts as one, oversize clamps to the maximum
	logic [CW-1:0] len_eff, fl_eff;

	always_comb begin
		if (line_length_q == '0)
			len_eff = CW'(1);
		else if (CW'(line_length_q) > CW'(MAX_LINE_SAMPLES))
			len_eff = CW'(MAX_LINE_SAMPLES);
		else
			len_eff = CW'(line_length_q);

		if (frame_lines_q == '0)
			fl_eff = CW'(1);
		else if (CW'(frame_lines_q) > CW'(MAX_FRAME_LINES))
			fl_eff = CW'(MAX_FRAME_LINES);
		else
			fl_eff = CW'(frame_lines_q);
	end

	// ---------------- accept and counters ----------------
	logic [PW-1:0] pos_q;
	logic [LW-1:0] line_q;
	logic          in_acc;
	logic          adv;
	logic          v_s1;
	logic          last_line, wrap, comb_en, emit_dly;
	logic [FP_W:0] count_q;

	assign adv           = v_s1 && (count_q <= (FP_W+1)'(FIFO_DEPTH - 2));
	assign samples.ready = !v_s1 || adv;
	assign in_acc        = samples.valid && samples.ready;

	assign last_line = (CW'(line_q) + CW'(1)) >= fl_eff;
	assign wrap      = (CW'(pos_q) + CW'(1)) >= len_eff;
	assign emit_dly  = line_q != '0;
	// combed when 16 <= L-1 and L-1+2 < frame_lines
	assign comb_en   = (CW'(line_q) >= CW'(clcf_pkg::FIRST_COMB_LINE + 1)) &&
		((CW'(line_q) + CW'(1)) < fl_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			line_q <= '0;
		end else if (in_acc) begin
			if (wrap) begin
				pos_q  <= '0;
				line_q <= last_line ? '0 : line_q + LW'(1);
			end else begin
				pos_q <= pos_q + PW'(1);
			end
		end
	end

	// ---------------- stage 1 ----------------
	logic signed [SW-1:0] s_s1;
	logic [PW-1:0]        p_s1;
	logic [LW-1:0]        l_s1;
	logic                 comb_s1, dly_s1, lastln_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (samples.ready)
			v_s1 <= samples.valid;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s_s1      <= samples.sample;
			p_s1      <= pos_q;
			l_s1      <= line_q;
			comb_s1   <= comb_en;
			dly_s1    <= emit_dly;
			lastln_s1 <= last_line;
		end
	end

	// line store: entry holds {upper, center}
	logic [2*SW-1:0] line_mem [MAX_LINE_SAMPLES];
	logic [2*SW-1:0] rd_s1;
	logic [2*SW-1:0] fwd_data_s1;
	logic            fwd_s1;
	logic [2*SW-1:0] ent_s1;
	logic signed [SW-1:0] c_s1, u_s1;

	assign ent_s1 = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign u_s1   = ent_s1[2*SW-1:SW];
	assign c_s1   = ent_s1[SW-1:0];

	always_ff @(posedge clk) begin
		if (adv)
			line_mem[p_s1] <= {c_s1, s_s1};
		if (in_acc)
			rd_s1 <= line_mem[pos_q];
	end

	// same-address read and write in one cycle (one-sample lines): bypass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fwd_s1 <= 1'b0;
		else if (in_acc)
			fwd_s1 <= adv && (p_s1 == pos_q);
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			fwd_data_s1 <= {c_s1, s_s1};
	end

	logic signed [QW-1:0] q_dly, q_cur;

	always_comb begin
		if (comb_s1)
			q_dly = (QW'(c_s1) <<< 1) - QW'(u_s1) - QW'(s_s1);
		else
			q_dly = QW'(c_s1) <<< 2;
		q_cur = QW'(s_s1) <<< 2;
	end

	clcf_pkg::result_t r_dly, r_cur;

	always_comb begin
		r_dly.comb_quarters = q_dly;
		r_dly.out_line      = clcf_pkg::OUT_LINE_W'(l_s1 - LW'(1));
		r_dly.out_pos       = clcf_pkg::OUT_POS_W'(p_s1);
		r_dly.last          = !lastln_s1;
		r_cur.comb_quarters = q_cur;
		r_cur.out_line      = clcf_pkg::OUT_LINE_W'(l_s1);
		r_cur.out_pos       = clcf_pkg::OUT_POS_W'(p_s1);
		r_cur.last          = 1'b1;
	end

	// ---------------- result buffer ----------------
	clcf_pkg::result_t fifo_q [FIFO_DEPTH];
	logic [FP_W-1:0]   wp_q, rp_q;
	logic              pop;
	logic [1:0]        push_n;

	assign pop    = results.valid && results.ready;
	assign push_n = adv ? (2'(dly_s1) + 2'(lastln_s1)) : 2'd0;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (dly_s1) begin
				fifo_q[wp_q] <= r_dly;
				if (lastln_s1)
					fifo_q[wp_q + FP_W'(1)] <= r_cur;
			end else if (lastln_s1) begin
				fifo_q[wp_q] <= r_cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + FP_W'(push_n);
			rp_q    <= rp_q + FP_W'(pop);
			count_q <= count_q + (FP_W+1)'(push_n) - (FP_W+1)'(pop);
		end
	end

	assign results.valid         = count_q != '0;
	assign results.comb_quarters = fifo_q[rp_q].comb_quarters;
	assign results.out_line      = fifo_q[rp_q].out_line;
	assign results.out_pos       = fifo_q[rp_q].out_pos;
	assign results.last          = fifo_q[rp_q].last;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FP_W+1)'(FIFO_DEPTH))
		else $error("result buffer overfilled");

	// a non-final result is always queued together with its partner
	a_pair_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.last) |-> (count_q >= (FP_W+1)'(2)))
		else $error("delayed result queued without current sample");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(p_s1) && $stable(s_s1)))
		else $error("stage 1 lost its item while stalled");

	a_fwd_one_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && adv && (p_s1 == pos_q)) |-> (len_eff == CW'(1)))
		else $error("store bypass on a line longer than one sample");
`endif

endmodule

/* verif/chroma_line_comb_filter_checker.sv */
// ----------------------------------------------------------------------------
// chroma_line_comb_filter_checker
// Watches the sample, result and APB ports of the comb filter. It keeps its
// own copy of the registers, both line stores and the raster counters, works
// out the results of each accepted sample, compares every accepted result
// field by field in order, and checks register read-back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chroma_line_comb_filter_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	clcf_in_if                              samples,
	clcf_out_if                             results,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [clcf_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [clcf_pkg::APB_DATA_W-1:0] pwdata,
	input  logic [clcf_pkg::APB_DATA_W-1:0] prdata,
	input  logic                            pready,
	output int                              errors,
	output int                              pending
);

	localparam int LINE_SAMPLES_MAX = 2048;
	localparam int FRAME_LINES_MAX  = 1024;

	logic [clcf_pkg::LINE_LEN_W-1:0]      line_length_q;
	logic [clcf_pkg::FRAME_LN_W-1:0]      frame_lines_q;
	logic signed [clcf_pkg::SAMPLE_W-1:0] center_store [LINE_SAMPLES_MAX];
	logic signed [clcf_pkg::SAMPLE_W-1:0] upper_store  [LINE_SAMPLES_MAX];
	logic [clcf_pkg::OUT_POS_W-1:0]       pos_q;
	logic [clcf_pkg::OUT_LINE_W-1:0]      line_q;

	clcf_pkg::result_t                    comb_results_due [$];
	clcf_pkg::result_t                    due;
	logic [clcf_pkg::APB_DATA_W-1:0]      reg_readback;
	int                                   fail_count;

	function automatic int clamp_count(input int v, input int maxv);
		if (v == 0)
			return 1;
		return (v > maxv) ? maxv : v;
	endfunction

	function automatic void report_mismatch(input string what, input longint exp_v,
		input longint act_v);
		fail_count++;
		$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
	endfunction

	// one sample: delayed (possibly combed) result of the line above, then the
	// sample itself on the frame's last line; then stores and counters move on
	task automatic filter_sample(input logic signed [clcf_pkg::SAMPLE_W-1:0] s);
		int len;
		int fl;
		int p;
		int ln;
		int c;
		int u;
		int q;
		bit last_line;
		clcf_pkg::result_t r;
		len = clamp_count(line_length_q, LINE_SAMPLES_MAX);
		fl = clamp_count(frame_lines_q, FRAME_LINES_MAX);
		p = pos_q;
		ln = line_q;
		c = center_store[p];
		u = upper_store[p];
		last_line = (ln + 1 >= fl);
		if (ln >= 1) begin
			if (ln - 1 >= clcf_pkg::FIRST_COMB_LINE && ln + 1 < fl)
				q = 2 * c - u - s;
			else
				q = 4 * c;
			r.comb_quarters = q[clcf_pkg::QUARTER_W-1:0];
			r.out_line = clcf_pkg::OUT_LINE_W'(ln - 1);
			r.out_pos = clcf_pkg::OUT_POS_W'(p);
			r.last = !last_line;
			comb_results_due = {comb_results_due, r};
		end
		if (last_line) begin
			q = 4 * s;
			r.comb_quarters = q[clcf_pkg::QUARTER_W-1:0];
			r.out_line = clcf_pkg::OUT_LINE_W'(ln);
			r.out_pos = clcf_pkg::OUT_POS_W'(p);
			r.last = 1'b1;
			comb_results_due = {comb_results_due, r};
		end
		upper_store[p] = center_store[p];
		center_store[p] = s;
		if (p + 1 >= len) begin
			pos_q = '0;
			line_q = last_line ? '0 : clcf_pkg::OUT_LINE_W'(ln + 1);
		end else begin
			pos_q = clcf_pkg::OUT_POS_W'(p + 1);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q = clcf_pkg::LINE_LENGTH_RESET;
			frame_lines_q = clcf_pkg::FRAME_LINES_RESET;
			pos_q = '0;
			line_q = '0;
			comb_results_due.delete();
			fail_count = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			// results first, so a sample accepted at this edge cannot match
			if (results.valid && results.ready) begin
				if (comb_results_due.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result: expected none, actual q=%0d line=%0d pos=%0d last=%0b",
						$time, results.comb_quarters, results.out_line, results.out_pos,
						results.last);
				end else begin
					due = comb_results_due.pop_front();
					if (due.comb_quarters != results.comb_quarters)
						report_mismatch("comb_quarters", $signed(due.comb_quarters),
							$signed(results.comb_quarters));
					if (due.out_line != results.out_line)
						report_mismatch("out_line", due.out_line, results.out_line);
					if (due.out_pos != results.out_pos)
						report_mismatch("out_pos", due.out_pos, results.out_pos);
					if (due.last != results.last)
						report_mismatch("last", due.last, results.last);
				end
			end
			if (samples.valid && samples.ready)
				filter_sample(samples.sample);
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == clcf_pkg::REG_LINE_LENGTH)
						line_length_q = pwdata[clcf_pkg::LINE_LEN_W-1:0];
					else
						frame_lines_q = pwdata[clcf_pkg::FRAME_LN_W-1:0];
				end else begin
					reg_readback = (paddr[2] == clcf_pkg::REG_LINE_LENGTH) ?
						clcf_pkg::APB_DATA_W'(line_length_q) :
						clcf_pkg::APB_DATA_W'(frame_lines_q);
					if (prdata != reg_readback)
						report_mismatch("prdata", reg_readback, prdata);
				end
			end
			errors <= fail_count;
			pending <= comb_results_due.size();
		end
	end

endmodule

/* verif/chroma_line_comb_filter_tb.sv */
// ----------------------------------------------------------------------------
// chroma_line_comb_filter_tb
// Drives the comb filter with directed frames (field extremes, one-line and
// zero-length frames, full-scale comb sums), then random frames under many
// line/frame settings, including oversize lengths and mid-frame shrinks.
// Both ports idle at random; the result side also holds off long enough to
// back up the sample port. The checker does all prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chroma_line_comb_filter_tb;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int DRAIN_CYCLES    = 8;
	localparam int ITEM_TARGET     = 1150;
	localparam int LINE_SAMPLES_MAX = 2048;
	localparam int FRAME_LINES_MAX = 1024;

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [clcf_pkg::APB_ADDR_W-1:0] paddr;
	logic [clcf_pkg::APB_DATA_W-1:0] pwdata;
	logic [clcf_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;
	int                              fail_total;
	int                              outstanding;
	int                              cycles;

	// raster position of the next sample, kept only to plan register changes
	int cur_len;
	int cur_lines;
	int track_pos;
	int track_line;
	int items_sent;
	bit gaps_on;

	clcf_in_if  samples();
	clcf_out_if results();

	chroma_line_comb_filter uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.results (results),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	chroma_line_comb_filter_checker cmp (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.results (results),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.errors  (fail_total),
		.pending (outstanding)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic signed [clcf_pkg::SAMPLE_W-1:0] any_sample();
		case ($urandom_range(0, 15))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return clcf_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic push_sample(input logic signed [clcf_pkg::SAMPLE_W-1:0] value);
		while (gaps_on && $urandom_range(0, 99) < 25) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.sample <= value;
		do @(posedge clk); while (!samples.ready);
		items_sent++;
		if (track_pos + 1 >= cur_len) begin
			track_pos = 0;
			track_line = (track_line + 1 >= cur_lines) ? 0 : track_line + 1;
		end else begin
			track_pos++;
		end
	endtask

	// called at the step of the last accepted request
	task automatic wait_idle();
		samples.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic which, input int data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {which, 2'b00};
		pwdata <= clcf_pkg::APB_DATA_W'(data);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic which, input int value);
		int eff;
		if (which == clcf_pkg::REG_LINE_LENGTH) begin
			eff = (value == 0) ? 1 : ((value > LINE_SAMPLES_MAX) ? LINE_SAMPLES_MAX : value);
			// a longer line must start on line 0, else line L reads unwritten entries
			while (eff > cur_len && track_line != 0)
				push_sample(any_sample());
		end else begin
			eff = (value == 0) ? 1 : ((value > FRAME_LINES_MAX) ? FRAME_LINES_MAX : value);
		end
		wait_idle();
		apb_access(1'b1, which, value);
		apb_access(1'b0, which, 0);
		if (which == clcf_pkg::REG_LINE_LENGTH)
			cur_len = eff;
		else
			cur_lines = eff;
	endtask

	// result side: random stalls, a quiet window, and two long hold-offs that
	// start while samples are on offer so the input backs up
	initial begin : result_sink
		int taken;
		int hold_left;
		int holds_done;
		taken = 0;
		hold_left = 0;
		holds_done = 0;
		results.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (results.valid && results.ready)
				taken++;
			if (hold_left == 0 && holds_done < 2 && taken >= 300 + holds_done * 500 &&
				samples.valid) begin
				hold_left = 500;
				holds_done++;
			end
			if (hold_left > 0) begin
				results.ready <= 1'b0;
				hold_left--;
			end else if (taken >= 850 && taken < 1100) begin
				results.ready <= 1'b1;
			end else begin
				results.ready <= ($urandom_range(0, 99) >= 25);
			end
		end
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		logic [clcf_pkg::SAMPLE_W-1:0] ladder [20];
		int phase_no;
		int n;
		// lines 15..19 of a 20-line, 1-sample frame: full-scale positive and
		// negative comb sums, then both last-line results at the extremes
		ladder = '{16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA,
			16'h7FFF, 16'h8000, 16'h0100, 16'hFEFF, 16'h1234,
			16'hEDCB, 16'h4000, 16'hC000, 16'h0002, 16'hFFFE,
			16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
		phase_no = 0;
		arst_n = 1'b0;
		samples.valid = 1'b0;
		samples.sample = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cur_len = clcf_pkg::LINE_LENGTH_RESET;
		cur_lines = clcf_pkg::FRAME_LINES_RESET;
		track_pos = 0;
		track_line = 0;
		items_sent = 0;
		gaps_on = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero lengths: one-sample lines in one-line frames, sample passes through
		write_reg(clcf_pkg::REG_LINE_LENGTH, 0);
		write_reg(clcf_pkg::REG_FRAME_LINES, 0);
		push_sample(16'h7FFF);
		push_sample(16'h8000);
		push_sample(16'h0000);
		push_sample(16'hFFFF);

		write_reg(clcf_pkg::REG_LINE_LENGTH, 1);
		write_reg(clcf_pkg::REG_FRAME_LINES, 20);
		foreach (ladder[i])
			push_sample(ladder[i]);

		while (items_sent < ITEM_TARGET) begin
			phase_no++;
			if ($urandom_range(0, 9) < 6) begin
				case ($urandom_range(0, 9))
					0: n = 0;
					1: n = $urandom_range(1, 18);
					default: n = $urandom_range(19, 40);
				endcase
				write_reg(clcf_pkg::REG_FRAME_LINES, n);
			end
			if ($urandom_range(0, 9) < 6) begin
				case ($urandom_range(0, 9))
					0: n = 0;
					1: n = $urandom_range(17, 40);
					default: n = $urandom_range(1, 16);
				endcase
				write_reg(clcf_pkg::REG_LINE_LENGTH, n);
			end
			gaps_on = (phase_no != 3);
			n = $urandom_range(80, 200);
			repeat (n) push_sample(any_sample());
		end
		gaps_on = 1'b1;

		// oversize line: acts as the longest line, no early wrap
		write_reg(clcf_pkg::REG_FRAME_LINES, 1);
		write_reg(clcf_pkg::REG_LINE_LENGTH, 4095);
		repeat (40) push_sample(any_sample());

		// oversize frame: acts as the tallest frame, lines keep counting
		write_reg(clcf_pkg::REG_FRAME_LINES, 2047);
		write_reg(clcf_pkg::REG_LINE_LENGTH, 1);
		repeat (40) push_sample(any_sample());

		wait_idle();
		if (fail_total == 0 && outstanding == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/clcf_pkg.sv
rtl/core/clcf_in_if.sv
rtl/core/clcf_out_if.sv
rtl/core/chroma_line_comb_filter.sv
verif/chroma_line_comb_filter_checker.sv
verif/chroma_line_comb_filter_tb.sv
